[design/bvft_pkg.sv]
// Shared constants and field widths for the bounding-volume frustum test core.
package bvft_pkg;

  // Coordinate width of centers; extents are one bit narrower and unsigned
  localparam int COORD_BITS = 16;
  localparam int EXT_BITS   = COORD_BITS - 1;

  // Plane register layout: three Q1.14 normal components and a Q12.4 offset
  localparam int NRM_BITS   = 16;
  localparam int NRM_FRAC   = 14;
  localparam int PLANE_BITS = 4 * NRM_BITS;
  localparam int NUM_PLANES = 6;
  localparam int AXES       = 3;
  localparam int CFG_IDX_W  = $clog2(NUM_PLANES);

  // Product and accumulation widths
  localparam int PROD_W  = NRM_BITS + COORD_BITS;  // signed normal * center
  localparam int PRODU_W = NRM_BITS + EXT_BITS;    // |normal| * extent
  localparam int SUM_W   = PROD_W + 4;             // distance plus margin

  // Stream payload widths
  localparam int IN_FIELD_BITS = AXES * COORD_BITS + AXES * EXT_BITS;
  localparam int IN_TDATA_W    = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = 8;
  localparam int OP_W          = 2;

  // Volume kinds carried on tuser
  localparam logic [OP_W-1:0] OP_BOX    = 2'd0;
  localparam logic [OP_W-1:0] OP_CUBE   = 2'd1;
  localparam logic [OP_W-1:0] OP_SPHERE = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

  typedef logic [PLANE_BITS-1:0] plane_t;

endpackage

[design/bounding_volume_frustum_test_core.sv]
// Box, cube and sphere culling against six frustum planes, four-stage pipeline.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tuser: operation; tdata: centers, extents
//  out_    | out | out_tvalid/out_tready | tdata: visible
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index plane select, cfg_data plane word
//
// One item enters per cycle unless back-pressure fills every stage; results leave in order.
// Stages: products, distance and margin sums, per-plane compare, output register.
// Each stage holds on its own only while everything downstream is full, so bubbles
// close up under back-pressure. rst_n (synchronous) clears valid bits and planes.
// Configuration writes are always taken; index values past the far plane are dropped.
module bounding_volume_frustum_test_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] center_x, [31:16] center_y, [47:32] center_z,
  // [62:48] extent_x, [77:63] extent_y, [92:78] extent_z, rest zero
  input  logic [bvft_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] operation
  input  logic [bvft_pkg::OP_W-1:0]           in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] visible, rest zero
  output logic [bvft_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bvft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bvft_pkg::PLANE_BITS-1:0]     cfg_data
);

  localparam int CW = bvft_pkg::COORD_BITS;
  localparam int EW = bvft_pkg::EXT_BITS;
  localparam int NW = bvft_pkg::NRM_BITS;
  localparam int NP = bvft_pkg::NUM_PLANES;
  localparam int NA = bvft_pkg::AXES;
  localparam int PW = bvft_pkg::PROD_W;
  localparam int UW = bvft_pkg::PRODU_W;
  localparam int SW = bvft_pkg::SUM_W;

  // ---------------------------------------------------------------------------
  // Plane registers
  // ---------------------------------------------------------------------------
  bvft_pkg::plane_t plane_r [NP];

  assign cfg_ready = 1'b1;

  // Store a plane word on each configuration transfer that addresses a plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NP; p++) begin
        plane_r[p] <= '0;
      end
    end else if (cfg_valid && (cfg_index < bvft_pkg::CFG_IDX_W'(NP))) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  // Plane fields
  logic signed [NW-1:0] nrm   [NP][NA];
  logic        [NW-1:0] nrm_a [NP][NA];
  logic signed [NW-1:0] ofs   [NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int a = 0; a < NA; a++) begin
        nrm[p][a]   = signed'(plane_r[p][a*NW +: NW]);
        nrm_a[p][a] = nrm[p][a][NW-1] ? NW'(-nrm[p][a]) : NW'(nrm[p][a]);
      end
      ofs[p] = signed'(plane_r[p][NA*NW +: NW]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshakes
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !out_v_r || out_tready;
  assign rdy3      = !s3_v_r  || rdy4;
  assign rdy2      = !s2_v_r  || rdy3;
  assign rdy1      = !s1_v_r  || rdy2;
  assign in_tready = rdy1;

  // ---------------------------------------------------------------------------
  // Stage 1: products of normals with center and with extents
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] in_ctr [NA];
  logic        [EW-1:0] in_ext [NA];
  logic        [EW-1:0] ext_eff [NA];

  logic signed [PW-1:0] s1_nc_nxt [NP][NA];
  logic        [UW-1:0] s1_ne_nxt [NP][NA];
  logic signed [PW-1:0] s1_nc_r   [NP][NA];
  logic        [UW-1:0] s1_ne_r   [NP][NA];
  logic [bvft_pkg::OP_W-1:0] s1_op_r;
  logic [EW-1:0]             s1_ex_r;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      in_ctr[a] = signed'(in_tdata[a*CW +: CW]);
      in_ext[a] = in_tdata[NA*CW + a*EW +: EW];
    end
    // A cube uses its one half size on every axis
    ext_eff[0] = in_ext[0];
    for (int a = 1; a < NA; a++) begin
      ext_eff[a] = (in_tuser == bvft_pkg::OP_CUBE) ? in_ext[0] : in_ext[a];
    end
    for (int p = 0; p < NP; p++) begin
      for (int a = 0; a < NA; a++) begin
        s1_nc_nxt[p][a] = PW'(nrm[p][a] * in_ctr[a]);
        s1_ne_nxt[p][a] = UW'(nrm_a[p][a] * ext_eff[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_nc_r <= s1_nc_nxt;
      s1_ne_r <= s1_ne_nxt;
      s1_op_r <= in_tuser;
      s1_ex_r <= in_ext[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: signed distance n.c - d and the allowed margin, both in Q.18
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s2_dist_nxt [NP];
  logic signed [SW-1:0] s2_marg_nxt [NP];
  logic signed [SW-1:0] s2_dist_r   [NP];
  logic signed [SW-1:0] s2_marg_r   [NP];
  logic [bvft_pkg::OP_W-1:0] s2_op_r;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      s2_dist_nxt[p] = SW'(s1_nc_r[p][0]) + SW'(s1_nc_r[p][1]) + SW'(s1_nc_r[p][2])
                     - (SW'(ofs[p]) <<< bvft_pkg::NRM_FRAC);
      // Sphere margin is the radius; box and cube project their extents
      if (s1_op_r == bvft_pkg::OP_SPHERE) begin
        s2_marg_nxt[p] = signed'(SW'(s1_ex_r) << bvft_pkg::NRM_FRAC);
      end else begin
        s2_marg_nxt[p] = signed'(SW'(s1_ne_r[p][0]) + SW'(s1_ne_r[p][1])
                                 + SW'(s1_ne_r[p][2]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_dist_r <= s2_dist_nxt;
      s2_marg_r <= s2_marg_nxt;
      s2_op_r   <= s1_op_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-plane pass; a sphere needs a strictly positive sum
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s3_sum [NP];
  logic [NP-1:0]        s3_pass_nxt;
  logic [NP-1:0]        s3_pass_r;
  logic [bvft_pkg::OP_W-1:0] s3_op_r;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      s3_sum[p]      = s2_dist_r[p] + s2_marg_r[p];
      s3_pass_nxt[p] = !s3_sum[p][SW-1]
                       && ((s3_sum[p] != '0) || (s2_op_r != bvft_pkg::OP_SPHERE));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_pass_r <= s3_pass_nxt;
      s3_op_r   <= s2_op_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: combine planes, drop the unused kind, hold for the sink
  // ---------------------------------------------------------------------------
  logic vis_nxt, vis_r;

  assign vis_nxt = (&s3_pass_r) && (s3_op_r != bvft_pkg::OP_RSVD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy4) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      vis_r <= vis_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(bvft_pkg::OUT_TDATA_W-1){1'b0}}, vis_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Input back-pressure only ever comes from a blocked output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

  // The unused kind never reports a visible volume
  a_rsvd_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && rdy4 && (s3_op_r == bvft_pkg::OP_RSVD)) |=> !out_tdata[0])
    else $error("unused operation produced visible result");

  // A full stage 3 with a free output always moves into the output register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && rdy4) |=> out_tvalid)
    else $error("stage 3 transfer lost");

  // A held stage 2 item stays put while stage 3 cannot take it
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !rdy3) |=> (s2_v_r && $stable(s2_op_r)))
    else $error("stage 2 item changed while stalled");

endmodule

[verif/tb.sv]
// Self-checking testbench for the box, cube and sphere frustum culling core.
module tb;

  // Plane register indexes, two of them past the far plane
  localparam logic [bvft_pkg::CFG_IDX_W-1:0] IDX_LEFT   = 3'd0;
  localparam logic [bvft_pkg::CFG_IDX_W-1:0] IDX_RIGHT  = 3'd1;
  localparam logic [bvft_pkg::CFG_IDX_W-1:0] IDX_TOP    = 3'd2;
  localparam logic [bvft_pkg::CFG_IDX_W-1:0] IDX_BOTTOM = 3'd3;
  localparam logic [bvft_pkg::CFG_IDX_W-1:0] IDX_NEAR   = 3'd4;
  localparam logic [bvft_pkg::CFG_IDX_W-1:0] IDX_FAR    = 3'd5;
  localparam logic [bvft_pkg::CFG_IDX_W-1:0] IDX_SPARE0 = 3'd6;
  localparam logic [bvft_pkg::CFG_IDX_W-1:0] IDX_SPARE1 = 3'd7;

  // Q1.14 unit normal
  localparam int ONE = 16384;

  typedef struct packed {
    logic [bvft_pkg::OP_W-1:0]              op;
    logic signed [bvft_pkg::COORD_BITS-1:0] cx;
    logic signed [bvft_pkg::COORD_BITS-1:0] cy;
    logic signed [bvft_pkg::COORD_BITS-1:0] cz;
    logic [bvft_pkg::EXT_BITS-1:0]          ex;
    logic [bvft_pkg::EXT_BITS-1:0]          ey;
    logic [bvft_pkg::EXT_BITS-1:0]          ez;
  } volume_t;

  localparam logic [bvft_pkg::OP_W-1:0] VALID_KINDS [3] =
    '{bvft_pkg::OP_BOX, bvft_pkg::OP_CUBE, bvft_pkg::OP_SPHERE};

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [bvft_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [bvft_pkg::OP_W-1:0]        in_tuser = bvft_pkg::OP_BOX;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [bvft_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [bvft_pkg::CFG_IDX_W-1:0]   cfg_index = IDX_LEFT;
  logic [bvft_pkg::PLANE_BITS-1:0]  cfg_data = '0;

  bounding_volume_frustum_test_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  volume_t                          volume_q[$];     // volumes waiting to be sent
  logic [bvft_pkg::OUT_TDATA_W-1:0] visible_q[$];    // predicted result bytes, oldest first
  bvft_pkg::plane_t                 plane_shadow [bvft_pkg::NUM_PLANES];
  volume_t                          in_volume;       // volume currently on the input bus
  logic                             in_taken = 1'b0;
  int                               cfg_count = 0;
  int                               mismatch_count = 0;
  int                               in_idle_pct = 0;
  int                               out_idle_pct = 0;

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Predict the visible flag against the shadow copy of the planes
  function automatic logic volume_visible(volume_t v);
    longint cx, cy, cz, ex, ey, ez, nx, ny, nz, d, sdist, margin;
    logic   keep;
    keep = (v.op != bvft_pkg::OP_RSVD);
    cx = $signed(v.cx);
    cy = $signed(v.cy);
    cz = $signed(v.cz);
    ex = v.ex;
    ey = v.ey;
    ez = v.ez;
    for (int i = 0; i < bvft_pkg::NUM_PLANES; i++) begin
      nx = $signed(plane_shadow[i][15:0]);
      ny = $signed(plane_shadow[i][31:16]);
      nz = $signed(plane_shadow[i][47:32]);
      d  = $signed(plane_shadow[i][63:48]);
      sdist = nx * cx + ny * cy + nz * cz - d * ONE;
      case (v.op)
        bvft_pkg::OP_SPHERE: margin = ex * ONE;
        bvft_pkg::OP_CUBE:   margin = ex * (mag(nx) + mag(ny) + mag(nz));
        default:             margin = ex * mag(nx) + ey * mag(ny) + ez * mag(nz);
      endcase
      // a sphere must be strictly in front; a box or cube may touch
      if (v.op == bvft_pkg::OP_SPHERE) keep = keep && (sdist > -margin);
      else                             keep = keep && (sdist >= -margin);
    end
    return keep;
  endfunction

  function automatic volume_t mk_volume(logic [bvft_pkg::OP_W-1:0] op, int cx, int cy,
                                        int cz, int ex, int ey, int ez);
    volume_t v;
    v.op = op;
    v.cx = bvft_pkg::COORD_BITS'(cx);
    v.cy = bvft_pkg::COORD_BITS'(cy);
    v.cz = bvft_pkg::COORD_BITS'(cz);
    v.ex = bvft_pkg::EXT_BITS'(ex);
    v.ey = bvft_pkg::EXT_BITS'(ey);
    v.ez = bvft_pkg::EXT_BITS'(ez);
    return v;
  endfunction

  function automatic bvft_pkg::plane_t mk_plane(int nx, int ny, int nz, int d);
    return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  // Mostly within +-spread of the origin, sometimes anywhere
  function automatic int rand_coord(int spread);
    if ($urandom_range(7) == 0) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic int rand_extent(int spread);
    if ($urandom_range(7) == 0) return int'($urandom_range(32767));
    return int'($urandom_range(spread / 4));
  endfunction

  function automatic volume_t rand_volume(int spread);
    logic [bvft_pkg::OP_W-1:0] op;
    if ($urandom_range(15) == 0) op = bvft_pkg::OP_RSVD;
    else                         op = VALID_KINDS[2'($urandom_range(2))];
    return mk_volume(op, rand_coord(spread), rand_coord(spread), rand_coord(spread),
                     rand_extent(spread), rand_extent(spread), rand_extent(spread));
  endfunction

  // Tilted plane whose offset keeps the origin on the visible side
  function automatic bvft_pkg::plane_t rand_plane();
    return mk_plane(int'($urandom_range(32767)) - ONE, int'($urandom_range(32767)) - ONE,
                    int'($urandom_range(32767)) - ONE, -int'($urandom_range(3200)));
  endfunction

  // Drive the input stream and the result ready at the falling edge
  always @(negedge clk) begin
    volume_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (volume_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = volume_q.pop_front();
        in_volume <= nxt;
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.op;
        in_tdata  <= {3'b000, nxt.ez, nxt.ey, nxt.ex, nxt.cz, nxt.cy, nxt.cx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Sample transfers at the rising edge: config shadow, result check, prediction
  always @(posedge clk) begin
    logic [bvft_pkg::OUT_TDATA_W-1:0] want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      for (int i = 0; i < bvft_pkg::NUM_PLANES; i++) plane_shadow[i] <= '0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < bvft_pkg::NUM_PLANES) plane_shadow[cfg_index] <= cfg_data;
        cfg_count <= cfg_count + 1;
      end
      if (out_tvalid && out_tready) begin
        if (visible_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = visible_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: visible mismatch, expected %h, actual %h", $time, want, out_tdata);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        visible_q.push_back({{(bvft_pkg::OUT_TDATA_W-1){1'b0}}, volume_visible(in_volume)});
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic write_plane(input logic [bvft_pkg::CFG_IDX_W-1:0] idx,
                             input bvft_pkg::plane_t word);
    int seen;
    seen = cfg_count;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(negedge clk); while (cfg_count == seen);
  endtask

  // Hold off until every sent volume has its result, plus an idle margin beyond pipeline depth
  task automatic drain();
    @(negedge clk);
    while (volume_q.size() != 0 || in_tvalid || visible_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic push_random(int count, int spread);
    for (int i = 0; i < count; i++) volume_q.push_back(rand_volume(spread));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_idle_pct  <= 22;
    out_idle_pct <= 72;

    // All-zero planes after reset: boxes and cubes pass, zero-radius spheres fail
    volume_q.push_back(mk_volume(bvft_pkg::OP_BOX, 32767, 32767, 32767, 32767, 32767, 32767));
    volume_q.push_back(mk_volume(bvft_pkg::OP_BOX, -32768, -32768, -32768, 0, 0, 0));
    volume_q.push_back(mk_volume(bvft_pkg::OP_CUBE, -32768, 32767, 0, 0, 32767, 32767));
    volume_q.push_back(mk_volume(bvft_pkg::OP_SPHERE, 0, 0, 0, 0, 32767, 32767));
    volume_q.push_back(mk_volume(bvft_pkg::OP_SPHERE, 32767, -32768, 0, 32767, 0, 0));
    volume_q.push_back(mk_volume(bvft_pkg::OP_SPHERE, 0, 0, 0, 1, 0, 0));
    volume_q.push_back(mk_volume(bvft_pkg::OP_RSVD, 0, 0, 0, 32767, 32767, 32767));
    drain();

    // Axis-aligned cube frustum, 100.0 units out on every side
    write_plane(IDX_LEFT,   mk_plane(ONE, 0, 0, -1600));
    write_plane(IDX_RIGHT,  mk_plane(-ONE, 0, 0, -1600));
    write_plane(IDX_TOP,    mk_plane(0, -ONE, 0, -1600));
    write_plane(IDX_BOTTOM, mk_plane(0, ONE, 0, -1600));
    write_plane(IDX_NEAR,   mk_plane(0, 0, ONE, -1600));
    write_plane(IDX_FAR,    mk_plane(0, 0, -ONE, -1600));
    cfg_valid <= 1'b0;

    // Box exactly touching the left plane, then one step beyond
    volume_q.push_back(mk_volume(bvft_pkg::OP_BOX, -1760, 0, 0, 160, 0, 0));
    volume_q.push_back(mk_volume(bvft_pkg::OP_BOX, -1761, 0, 0, 160, 0, 0));
    // Box touching the top plane through its y extent
    volume_q.push_back(mk_volume(bvft_pkg::OP_BOX, 0, 1680, 0, 0, 80, 0));
    volume_q.push_back(mk_volume(bvft_pkg::OP_BOX, 0, 1681, 0, 0, 80, 0));
    // Cube ignores y and z extents
    volume_q.push_back(mk_volume(bvft_pkg::OP_CUBE, 0, 1700, 0, 0, 32767, 32767));
    volume_q.push_back(mk_volume(bvft_pkg::OP_CUBE, 0, 1700, 0, 100, 0, 0));
    // Sphere touching a plane is culled, one step inside is kept
    volume_q.push_back(mk_volume(bvft_pkg::OP_SPHERE, -1760, 0, 0, 160, 0, 0));
    volume_q.push_back(mk_volume(bvft_pkg::OP_SPHERE, -1759, 0, 0, 160, 32767, 32767));
    volume_q.push_back(mk_volume(bvft_pkg::OP_SPHERE, 0, 0, 1600, 0, 0, 0));
    volume_q.push_back(mk_volume(bvft_pkg::OP_SPHERE, 0, 0, 1599, 0, 0, 0));
    volume_q.push_back(mk_volume(bvft_pkg::OP_RSVD, 0, 0, 0, 0, 0, 0));
    push_random(100, 2400);
    // Pause the sender until every result is back, then resume
    drain();
    push_random(100, 2400);
    drain();

    // Tilted planes; spare indexes must leave them alone
    in_idle_pct  <= 72;
    out_idle_pct <= 22;
    write_plane(IDX_LEFT,   rand_plane());
    write_plane(IDX_RIGHT,  rand_plane());
    write_plane(IDX_TOP,    rand_plane());
    write_plane(IDX_BOTTOM, rand_plane());
    write_plane(IDX_NEAR,   rand_plane());
    write_plane(IDX_FAR,    rand_plane());
    write_plane(IDX_SPARE0, {$urandom, $urandom});
    write_plane(IDX_SPARE1, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    push_random(200, 2400);
    drain();

    // Extreme normals and offsets
    in_idle_pct  <= 0;
    out_idle_pct <= 0;
    write_plane(IDX_LEFT,   64'h7FFF_7FFF_7FFF_7FFF);
    write_plane(IDX_RIGHT,  64'h8000_8000_8000_8000);
    write_plane(IDX_TOP,    64'hFFFF_FFFF_FFFF_FFFF);
    write_plane(IDX_BOTTOM, 64'h0000_0000_0000_0000);
    write_plane(IDX_NEAR,   64'h8000_7FFF_8000_7FFF);
    write_plane(IDX_FAR,    64'h7FFF_8000_7FFF_8000);
    cfg_valid <= 1'b0;
    push_random(100, 30000);
    drain();

    // Fully random plane words
    write_plane(IDX_LEFT,   {$urandom, $urandom});
    write_plane(IDX_RIGHT,  {$urandom, $urandom});
    write_plane(IDX_TOP,    {$urandom, $urandom});
    write_plane(IDX_BOTTOM, {$urandom, $urandom});
    write_plane(IDX_NEAR,   {$urandom, $urandom});
    write_plane(IDX_FAR,    {$urandom, $urandom});
    cfg_valid <= 1'b0;
    push_random(100, 30000);
    drain();

    if (visible_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected none, actual missing",
               $time, visible_q.size());
    end
    if (mismatch_count == 0 && visible_q.size() == 0) begin
      $display("** bounding_volume_frustum_test_core: PASSED **");
    end else begin
      $display("** bounding_volume_frustum_test_core: FAILED **");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #400000;
    $display("** bounding_volume_frustum_test_core: FAILED **");
    $finish;
  end

endmodule

[sim.f]
design/bvft_pkg.sv
design/bounding_volume_frustum_test_core.sv
verif/tb.sv
